// ===== sv/nsac_pkg.sv =====
`timescale 1ns / 1ps

package nsac_pkg;

  // default sizes
  localparam int STORE_DEPTH_DEF = 131072;
  localparam int DIM_BITS_DEF    = 10;

  // fixed field widths
  localparam int LOAD_ADDR_W = 17;
  localparam int PIXEL_W     = 16;
  localparam int COLOR_W     = 16;
  localparam int BASE_W      = 17;
  localparam int STRIDE_W    = 11;
  localparam int IN_DATA_W   = ((LOAD_ADDR_W + PIXEL_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_LEFT    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_TOP     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 4'd7;

  // item kinds carried on tuser
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // ARGB1555 layout
  localparam int ALPHA_BIT = 15;
  localparam int RED_LSB   = 10;
  localparam int GREEN_LSB = 5;
  localparam int CH_W      = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_ADD,
    ST_ROW_SUB,
    ST_ROW_STEP,
    ST_COL_ADD,
    ST_COL_SUB,
    ST_ADDR,
    ST_EMIT
  } state_t;

  // ARGB1555 to RGB565, green low bit repeats its msb, transparent gives zero
  function automatic logic [COLOR_W-1:0] to_rgb565(input logic [PIXEL_W-1:0] pix);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    r = pix[RED_LSB +: CH_W];
    g = pix[GREEN_LSB +: CH_W];
    b = pix[CH_W-1:0];
    if (pix[ALPHA_BIT]) begin
      return {r, g, g[CH_W-1], b};
    end
    return '0;
  endfunction

endpackage

// ===== sv/nearest_scaler_alpha_compositor.sv =====
`timescale 1ns / 1ps

// Nearest-neighbor scaler from an ARGB1555 source store to RGB565 screen pixels.
// An input transfer with tuser 0 writes one pixel into the source store. An
// input transfer with tuser 1 produces the next destination pixel in raster
// order, with its screen position, its RGB565 color (zero when transparent), a
// visible flag on tuser and tlast on the last pixel of the rectangle; with an
// empty destination it produces nothing. Source stepping runs through one
// shared add/subtract unit under a small sequencer, which at the start of each
// destination row steps the row address by the line stride per source row,
// then steps the column budget per source column and forms the store address.
// One item is in work at a time; the result register lets the next item enter
// while a result waits to leave. STORE_DEPTH must be a power of two; addresses
// wrap at the store depth. Configuration must be written only while the block
// is idle; the block itself does not enforce it.
module nearest_scaler_alpha_compositor #(
  parameter int STORE_DEPTH = nsac_pkg::STORE_DEPTH_DEF,
  parameter int DIM_BITS    = nsac_pkg::DIM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsac_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [nsac_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // load_addr, load_pixel, zero pad
  input  logic                              s_axis_tuser,  // func
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((2*(DIM_BITS+1)+nsac_pkg::COLOR_W+7)/8)*8-1:0]
                                            m_axis_tdata,  // screen_x, screen_y, color, zero pad
  output logic                              m_axis_tuser,  // visible
  output logic                              m_axis_tlast   // frame_end
);

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int NARROW_W = (ADDR_W > DIM_BITS + 1) ? ADDR_W : DIM_BITS + 1;
  localparam int ALU_W    = (NARROW_W > nsac_pkg::STRIDE_W) ? NARROW_W : nsac_pkg::STRIDE_W;
  localparam int OUT_BITS = 2 * (DIM_BITS + 1) + nsac_pkg::COLOR_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // configuration registers
  logic [nsac_pkg::BASE_W-1:0]   src_base;
  logic [nsac_pkg::STRIDE_W-1:0] line_stride;
  logic [DIM_BITS-1:0]           src_width;
  logic [DIM_BITS-1:0]           src_height;
  logic [DIM_BITS-1:0]           dst_left;
  logic [DIM_BITS-1:0]           dst_top;
  logic [DIM_BITS-1:0]           dst_width;
  logic [DIM_BITS-1:0]           dst_height;

  logic                              start;
  logic                              idle;
  logic                              load_we;
  logic [nsac_pkg::LOAD_ADDR_W-1:0]  load_addr;
  logic [nsac_pkg::PIXEL_W-1:0]      load_pixel;
  logic                              rd_en;
  logic [ADDR_W-1:0]                 rd_addr;
  logic [nsac_pkg::PIXEL_W-1:0]      rd_data;
  logic [DIM_BITS:0]                 screen_x;
  logic [DIM_BITS:0]                 screen_y;
  logic [nsac_pkg::COLOR_W-1:0]      color;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_base    <= '0;
      line_stride <= nsac_pkg::STRIDE_W'(1);
      src_width   <= '0;
      src_height  <= '0;
      dst_left    <= '0;
      dst_top     <= '0;
      dst_width   <= '0;
      dst_height  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsac_pkg::REG_SRC_BASE:    src_base    <= cfg_data[nsac_pkg::BASE_W-1:0];
        nsac_pkg::REG_LINE_STRIDE: line_stride <= cfg_data[nsac_pkg::STRIDE_W-1:0];
        nsac_pkg::REG_SRC_WIDTH:   src_width   <= cfg_data[DIM_BITS-1:0];
        nsac_pkg::REG_SRC_HEIGHT:  src_height  <= cfg_data[DIM_BITS-1:0];
        nsac_pkg::REG_DST_LEFT:    dst_left    <= cfg_data[DIM_BITS-1:0];
        nsac_pkg::REG_DST_TOP:     dst_top     <= cfg_data[DIM_BITS-1:0];
        nsac_pkg::REG_DST_WIDTH:   dst_width   <= cfg_data[DIM_BITS-1:0];
        nsac_pkg::REG_DST_HEIGHT:  dst_height  <= cfg_data[DIM_BITS-1:0];
        default:                   src_base    <= src_base;
      endcase
    end
  end

  // input unpacking
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign load_addr     = s_axis_tdata[nsac_pkg::LOAD_ADDR_W-1:0];
  assign load_pixel    = s_axis_tdata[nsac_pkg::LOAD_ADDR_W +: nsac_pkg::PIXEL_W];
  assign load_we       = start && (s_axis_tuser == nsac_pkg::FUNC_LOAD);

  nsac_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (ADDR_W'(load_addr)),
    .wr_data (load_pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nsac_ctrl #(
    .DIM_BITS (DIM_BITS),
    .ADDR_W   (ADDR_W),
    .ALU_W    (ALU_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (s_axis_tuser),
    .idle        (idle),
    .src_base    (ADDR_W'(src_base)),
    .line_stride (line_stride),
    .src_width   (src_width),
    .src_height  (src_height),
    .dst_left    (dst_left),
    .dst_top     (dst_top),
    .dst_width   (dst_width),
    .dst_height  (dst_height),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .color       (color),
    .visible     (m_axis_tuser),
    .frame_end   (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = OUT_W'({color, screen_y, screen_x});

endmodule

// ===== sv/nsac_alu.sv =====
`timescale 1ns / 1ps

module nsac_alu #(
  parameter int W = 17
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] result,
  output logic         pos
);

  logic [W-1:0] b_op;
  logic [W:0]   full;

  // shared add / subtract, pos flags a strictly greater than b on subtract
  assign b_op   = sub ? ~b : b;
  assign full   = {1'b0, a} + {1'b0, b_op} + (W+1)'(sub);
  assign result = full[W-1:0];
  assign pos    = sub & full[W] & (full[W-1:0] != '0);

endmodule

// ===== sv/nsac_store.sv =====
`timescale 1ns / 1ps

module nsac_store #(
  parameter int DEPTH  = nsac_pkg::STORE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [nsac_pkg::PIXEL_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [nsac_pkg::PIXEL_W-1:0] rd_data
);

  logic [nsac_pkg::PIXEL_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/nsac_ctrl.sv =====
`timescale 1ns / 1ps

module nsac_ctrl #(
  parameter int DIM_BITS = nsac_pkg::DIM_BITS_DEF,
  parameter int ADDR_W   = 17,
  parameter int ALU_W    = 17
) (
  input  logic                              clk,
  input  logic                              rst,
  // item start
  input  logic                              start,
  input  logic                              func,
  output logic                              idle,
  // configuration
  input  logic [ADDR_W-1:0]                 src_base,
  input  logic [nsac_pkg::STRIDE_W-1:0]     line_stride,
  input  logic [DIM_BITS-1:0]               src_width,
  input  logic [DIM_BITS-1:0]               src_height,
  input  logic [DIM_BITS-1:0]               dst_left,
  input  logic [DIM_BITS-1:0]               dst_top,
  input  logic [DIM_BITS-1:0]               dst_width,
  input  logic [DIM_BITS-1:0]               dst_height,
  // source store read
  output logic                              rd_en,
  output logic [ADDR_W-1:0]                 rd_addr,
  input  logic [nsac_pkg::PIXEL_W-1:0]      rd_data,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [DIM_BITS:0]                 screen_x,
  output logic [DIM_BITS:0]                 screen_y,
  output logic [nsac_pkg::COLOR_W-1:0]      color,
  output logic                              visible,
  output logic                              frame_end
);

  nsac_pkg::state_t state;
  nsac_pkg::state_t state_next;

  logic [DIM_BITS-1:0] col_count;
  logic [DIM_BITS-1:0] row_count;
  logic [DIM_BITS:0]   col_budget;
  logic [DIM_BITS:0]   row_budget;
  logic [DIM_BITS-1:0] src_col;
  logic [ADDR_W-1:0]   row_address;

  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_sub;
  logic [ALU_W-1:0] alu_result;
  logic             alu_pos;

  logic              render_go;
  logic              out_free;
  logic [DIM_BITS:0] col_inc;
  logic [DIM_BITS:0] row_inc;

  assign render_go = start && (func == nsac_pkg::FUNC_RENDER) &&
                     (dst_width != '0) && (dst_height != '0);
  assign out_free  = !out_valid || out_ready;
  assign idle      = (state == nsac_pkg::ST_IDLE);
  assign col_inc   = {1'b0, col_count} + (DIM_BITS+1)'(1);
  assign row_inc   = {1'b0, row_count} + (DIM_BITS+1)'(1);

  nsac_alu #(
    .W(ALU_W)
  ) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_result),
    .pos    (alu_pos)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nsac_pkg::ST_IDLE: begin
        if (render_go) begin
          state_next = (col_count == '0) ? nsac_pkg::ST_ROW_ADD : nsac_pkg::ST_COL_ADD;
        end
      end
      nsac_pkg::ST_ROW_ADD:  state_next = nsac_pkg::ST_ROW_SUB;
      nsac_pkg::ST_ROW_SUB: begin
        state_next = alu_pos ? nsac_pkg::ST_ROW_STEP : nsac_pkg::ST_COL_ADD;
      end
      nsac_pkg::ST_ROW_STEP: state_next = nsac_pkg::ST_ROW_SUB;
      nsac_pkg::ST_COL_ADD:  state_next = nsac_pkg::ST_COL_SUB;
      nsac_pkg::ST_COL_SUB: begin
        state_next = alu_pos ? nsac_pkg::ST_COL_SUB : nsac_pkg::ST_ADDR;
      end
      nsac_pkg::ST_ADDR:     state_next = nsac_pkg::ST_EMIT;
      nsac_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = nsac_pkg::ST_IDLE;
        end
      end
      default:               state_next = nsac_pkg::ST_IDLE;
    endcase
  end

  // shared unit operands and store read
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    rd_en   = 1'b0;
    case (state)
      nsac_pkg::ST_ROW_ADD: begin
        alu_a = ALU_W'(row_budget);
        alu_b = ALU_W'(src_height);
      end
      nsac_pkg::ST_ROW_SUB: begin
        alu_a   = ALU_W'(row_budget);
        alu_b   = ALU_W'(dst_height);
        alu_sub = 1'b1;
      end
      nsac_pkg::ST_ROW_STEP: begin
        alu_a = ALU_W'(row_address);
        alu_b = ALU_W'(line_stride);
      end
      nsac_pkg::ST_COL_ADD: begin
        alu_a = ALU_W'(col_budget);
        alu_b = ALU_W'(src_width);
      end
      nsac_pkg::ST_COL_SUB: begin
        alu_a   = ALU_W'(col_budget);
        alu_b   = ALU_W'(dst_width);
        alu_sub = 1'b1;
      end
      nsac_pkg::ST_ADDR: begin
        alu_a = ALU_W'(row_address);
        alu_b = ALU_W'(src_col);
        rd_en = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign rd_addr = alu_result[ADDR_W-1:0];

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // position counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      col_budget  <= '0;
      row_budget  <= '0;
      src_col     <= '0;
      row_address <= '0;
    end else begin
      case (state)
        nsac_pkg::ST_IDLE: begin
          if (render_go && col_count == '0) begin
            col_budget <= '0;
            src_col    <= '0;
            if (row_count == '0) begin
              row_address <= src_base;
              row_budget  <= '0;
            end
          end
        end
        nsac_pkg::ST_ROW_ADD: begin
          row_budget <= alu_result[DIM_BITS:0];
        end
        nsac_pkg::ST_ROW_SUB: begin
          if (alu_pos) begin
            row_budget <= alu_result[DIM_BITS:0];
          end
        end
        nsac_pkg::ST_ROW_STEP: begin
          row_address <= alu_result[ADDR_W-1:0];
        end
        nsac_pkg::ST_COL_ADD: begin
          col_budget <= alu_result[DIM_BITS:0];
        end
        nsac_pkg::ST_COL_SUB: begin
          if (alu_pos) begin
            col_budget <= alu_result[DIM_BITS:0];
            src_col    <= src_col + DIM_BITS'(1);
          end
        end
        nsac_pkg::ST_EMIT: begin
          if (out_free) begin
            if (col_inc >= {1'b0, dst_width}) begin
              col_count <= '0;
              if (row_inc >= {1'b0, dst_height}) begin
                row_count <= '0;
              end else begin
                row_count <= row_inc[DIM_BITS-1:0];
              end
            end else begin
              col_count <= col_inc[DIM_BITS-1:0];
            end
          end
        end
        default: begin
          col_count <= col_count;
        end
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == nsac_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == nsac_pkg::ST_EMIT && out_free) begin
      screen_x  <= {1'b0, dst_left} + {1'b0, col_count};
      screen_y  <= {1'b0, dst_top} + {1'b0, row_count};
      color     <= nsac_pkg::to_rgb565(rd_data);
      visible   <= rd_data[nsac_pkg::ALPHA_BIT];
      frame_end <= (col_inc >= {1'b0, dst_width}) && (row_inc >= {1'b0, dst_height});
    end
  end

endmodule
